/* rtl/core/zbpof_pkg.sv */
// zbpof_pkg: shared types and constants for the z-buffer point occlusion filter.
// No dependencies; imported by zbuffer_point_occlusion_filter.
package zbpof_pkg;

    localparam int DEPTH_W   = 16;
    localparam int COORD_W   = 16;
    localparam int LIM_W     = 13;   // holds a rounded Q4 coordinate and any image limit
    localparam int EPOCH_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFE;
    localparam logic [DEPTH_W-1:0] DEPTH_INF = 16'hFFFF;

    // epoch 0 marks a swept cell; live frames cycle through 1..EPOCH_LAST
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_CALC,
        ST_ADDR,
        ST_CRD,
        ST_CTST,
        ST_WIN,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/zbuffer_point_occlusion_filter.sv */
// zbuffer_point_occlusion_filter: per-pixel depth buffer in one simple dual-port RAM.
// Depends on zbpof_pkg.
//
// Usage
//   Point channel: a point beat is taken on a rising edge with start high and busy low.
//   Result channel: done pulses for one cycle with visible and the point's coordinates
//   and depth on the output ports. Every point gives exactly one result. The receiver
//   cannot stall; results must be taken in the cycle that done is high.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write only while busy is low.
// State sequence (from the accepting edge to done, inclusive of the done state)
//   filter disabled, invalid point or pixel outside the image: CALC, DONE
//   point fails the depth test: CALC, ADDR, CRD, CTST, DONE
//   point accepted: CALC to CTST as above, then WIN per cell of the clipped window (9 for
//   radius 1), one cell per cycle on the read port, the write port retiring the prior cell.
//   busy drops in the cycle after done; a new point may be taken in that cycle.
// Reset and frames
//   After reset the RAM is swept, one cell per cycle over all MAX_WIDTH*MAX_HEIGHT cells,
//   with busy high. A frame start bumps an 8-bit epoch stored with each cell; on epoch wrap
//   (every 255th frame start) the same sweep runs before that point is processed.
module zbuffer_point_occlusion_filter
    import zbpof_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        start,
    output logic                        busy,
    input  logic                        first_of_frame,
    input  logic                        point_valid,
    input  logic signed [COORD_W-1:0]   col_q4,
    input  logic signed [COORD_W-1:0]   row_q4,
    input  logic [DEPTH_W-1:0]          depth_mm,

    output logic                        done,
    output logic                        visible,
    output logic signed [COORD_W-1:0]   out_col_q4,
    output logic signed [COORD_W-1:0]   out_row_q4,
    output logic [DEPTH_W-1:0]          out_depth_mm,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DEPTH_W-1:0]          cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int MW    = EPOCH_W + DEPTH_W;

    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0]    ROW_PITCH = AW'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] W_MAX     = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] H_MAX     = LIM_W'(MAX_HEIGHT);
    localparam logic [2:0]       R_MAX     = 3'(MAX_WINDOW);

    // round Q4 to integer, halves away from zero; two's complement result
    function automatic logic [LIM_W-1:0] round_q4(input logic [COORD_W-1:0] q);
        logic [COORD_W:0] mag;
        logic [LIM_W-1:0] rm;
        mag = q[COORD_W-1] ? ((COORD_W+1)'(0) - {q[COORD_W-1], q}) : {1'b0, q};
        rm  = LIM_W'((mag + (COORD_W+1)'(8)) >> 4);
        return q[COORD_W-1] ? (LIM_W'(0) - rm) : rm;
    endfunction

    // configuration
    logic                   en_reg;
    logic [1:0]             radius_reg;
    logic [DEPTH_W-1:0]     tol_cfg_reg;
    logic [10:0]            width_reg;
    logic [10:0]            height_reg;

    // control
    state_t                 state_reg, state_next;
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [AW-1:0]          sweep_cnt_reg, sweep_cnt_next;
    logic                   resume_reg, resume_next;
    logic                   chk_vld_reg, chk_vld_next;

    // datapath
    logic [AW-1:0]          chk_addr_reg, chk_addr_next;
    logic [COORD_W-1:0]     col_reg, col_next;
    logic [COORD_W-1:0]     row_reg, row_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic                   pvalid_reg, pvalid_next;
    logic                   vis_reg, vis_next;
    logic [DEPTH_W-1:0]     dsat_reg, dsat_next;
    logic [DEPTH_W-1:0]     tol_reg, tol_next;
    logic [XW-1:0]          u_reg, u_next, u0_reg, u0_next, u1_reg, u1_next, wx_reg, wx_next;
    logic [YW-1:0]          v_reg, v_next, v0_reg, v0_next, v1_reg, v1_next, wy_reg, wy_next;
    logic [AW-1:0]          caddr_reg, caddr_next;
    logic [AW-1:0]          waddr_reg, waddr_next;
    logic [AW-1:0]          row_step_reg, row_step_next;

    // RAM
    logic [MW-1:0]          mem [CELLS];
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MW-1:0]          mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [MW-1:0]          rd_data_reg;

    logic [EPOCH_W-1:0]     rd_epoch;
    logic [DEPTH_W-1:0]     rd_depth;
    logic                   rd_written;
    logic                   chk_upd;

    // combinational helpers
    logic [LIM_W-1:0]       u_s, v_s, w_lim, h_lim;
    logic [LIM_W-1:0]       u_lo, u_hi, v_lo, v_hi;
    logic [2:0]             r_eff;
    logic                   in_img;
    logic [DEPTH_W:0]       near_sum;
    logic [DEPTH_W-1:0]     diff;

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign visible      = vis_reg;
    assign out_col_q4   = col_reg;
    assign out_row_q4   = row_reg;
    assign out_depth_mm = depth_reg;

    assign rd_epoch   = rd_data_reg[MW-1:DEPTH_W];
    assign rd_depth   = rd_data_reg[DEPTH_W-1:0];
    assign rd_written = (rd_epoch == epoch_reg);
    // window write-back of the cell read in the previous cycle
    assign chk_upd    = chk_vld_reg && (!rd_written || (dsat_reg < rd_depth));

    always_comb
    begin
        u_s   = round_q4(col_reg);
        v_s   = round_q4(row_reg);
        w_lim = (LIM_W'(width_reg) > W_MAX) ? W_MAX : LIM_W'(width_reg);
        h_lim = (LIM_W'(height_reg) > H_MAX) ? H_MAX : LIM_W'(height_reg);
        r_eff = (3'(radius_reg) > R_MAX) ? R_MAX : 3'(radius_reg);
        in_img = !u_s[LIM_W-1] && !v_s[LIM_W-1] && (u_s < w_lim) && (v_s < h_lim);
        u_lo = (u_s < LIM_W'(r_eff)) ? '0 : (u_s - LIM_W'(r_eff));
        v_lo = (v_s < LIM_W'(r_eff)) ? '0 : (v_s - LIM_W'(r_eff));
        u_hi = ((u_s + LIM_W'(r_eff)) > (w_lim - LIM_W'(1))) ? (w_lim - LIM_W'(1))
                                                               : (u_s + LIM_W'(r_eff));
        v_hi = ((v_s + LIM_W'(r_eff)) > (h_lim - LIM_W'(1))) ? (h_lim - LIM_W'(1))
                                                               : (v_s + LIM_W'(r_eff));
        near_sum = {1'b0, dsat_reg} + {1'b0, tol_reg};
        diff     = (dsat_reg > rd_depth) ? (dsat_reg - rd_depth) : (rd_depth - dsat_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        sweep_cnt_next = sweep_cnt_reg;
        resume_next    = resume_reg;
        chk_vld_next   = 1'b0;
        chk_addr_next  = chk_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        depth_next     = depth_reg;
        pvalid_next    = pvalid_reg;
        vis_next       = vis_reg;
        dsat_next      = dsat_reg;
        tol_next       = tol_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        u0_next        = u0_reg;
        u1_next        = u1_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        caddr_next     = caddr_reg;
        waddr_next     = waddr_reg;
        row_step_next  = row_step_reg;
        mem_re         = 1'b0;
        mem_raddr      = waddr_reg;
        mem_we         = 1'b0;
        mem_waddr      = chk_addr_reg;
        mem_wdata      = {epoch_reg, dsat_reg};

        if (chk_upd)
        begin
            mem_we    = 1'b1;
            mem_waddr = chk_addr_reg;
            mem_wdata = {epoch_reg, dsat_reg};
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    col_next    = col_q4;
                    row_next    = row_q4;
                    depth_next  = depth_mm;
                    pvalid_next = point_valid;
                    state_next  = ST_CALC;
                    if (first_of_frame)
                    begin
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            sweep_cnt_next = '0;
                            resume_next    = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                mem_we         = 1'b1;
                mem_waddr      = sweep_cnt_reg;
                mem_wdata      = {EPOCH_NONE, DEPTH_INF};
                sweep_cnt_next = sweep_cnt_reg + AW'(1);
                if (sweep_cnt_reg == LAST_CELL)
                begin
                    epoch_next = EPOCH_FIRST;
                    state_next = resume_reg ? ST_CALC : ST_IDLE;
                end
            end

            ST_CALC:
            begin
                dsat_next = (depth_reg == DEPTH_INF) ? DEPTH_MAX : depth_reg;
                tol_next  = (tol_cfg_reg == DEPTH_INF) ? DEPTH_MAX : tol_cfg_reg;
                u_next    = u_s[XW-1:0];
                v_next    = v_s[YW-1:0];
                u0_next   = u_lo[XW-1:0];
                u1_next   = u_hi[XW-1:0];
                v0_next   = v_lo[YW-1:0];
                v1_next   = v_hi[YW-1:0];
                if (!en_reg)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!pvalid_reg || !in_img)
                begin
                    vis_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ADDR;
                end
            end

            ST_ADDR:
            begin
                caddr_next    = AW'(v_reg) * ROW_PITCH + AW'(u_reg);
                waddr_next    = AW'(v0_reg) * ROW_PITCH + AW'(u0_reg);
                row_step_next = ROW_PITCH - AW'(u1_reg - u0_reg);
                wx_next       = u0_reg;
                wy_next       = v0_reg;
                state_next    = ST_CRD;
            end

            ST_CRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = caddr_reg;
                state_next = ST_CTST;
            end

            ST_CTST:
            begin
                if (!rd_written || (near_sum < {1'b0, rd_depth}))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = caddr_reg;
                    mem_wdata  = {epoch_reg, dsat_reg};
                    vis_next   = 1'b1;
                    state_next = ST_WIN;
                end
                else if (diff <= tol_reg)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_WIN;
                end
                else
                begin
                    vis_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_WIN:
            begin
                // read this cell; the check of the previous one retires on the write port
                mem_re        = 1'b1;
                mem_raddr     = waddr_reg;
                chk_vld_next  = 1'b1;
                chk_addr_next = waddr_reg;
                if (wx_reg == u1_reg)
                begin
                    if (wy_reg == v1_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        wx_next    = u0_reg;
                        wy_next    = wy_reg + YW'(1);
                        waddr_next = waddr_reg + row_step_reg;
                    end
                end
                else
                begin
                    wx_next    = wx_reg + XW'(1);
                    waddr_next = waddr_reg + AW'(1);
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            epoch_reg     <= EPOCH_NONE;
            sweep_cnt_reg <= '0;
            resume_reg    <= 1'b0;
            chk_vld_reg   <= 1'b0;
            en_reg        <= 1'b1;
            radius_reg    <= 2'd1;
            tol_cfg_reg   <= 16'd150;
            width_reg     <= 11'd1024;
            height_reg    <= 11'd1024;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            sweep_cnt_reg <= sweep_cnt_next;
            resume_reg    <= resume_next;
            chk_vld_reg   <= chk_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FILTER_ENABLE: en_reg      <= cfg_data[0];
                    CFG_WINDOW_RADIUS: radius_reg  <= cfg_data[1:0];
                    CFG_DEPTH_TOL:     tol_cfg_reg <= cfg_data;
                    CFG_IMAGE_WIDTH:   width_reg   <= cfg_data[10:0];
                    CFG_IMAGE_HEIGHT:  height_reg  <= cfg_data[10:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        depth_reg    <= depth_next;
        pvalid_reg   <= pvalid_next;
        vis_reg      <= vis_next;
        dsat_reg     <= dsat_next;
        tol_reg      <= tol_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        u0_reg       <= u0_next;
        u1_reg       <= u1_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        caddr_reg    <= caddr_next;
        waddr_reg    <= waddr_next;
        row_step_reg <= row_step_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // a taken point always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted point did not start processing");

    // each done strobe is followed by done low
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // no window write-back can be pending while the RAM is being swept
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !chk_vld_reg)
        else $error("window check overlaps sweep");

    // point writes carry the live epoch and a finite depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != ST_SWEEP)) |->
            ((mem_wdata[MW-1:DEPTH_W] == epoch_reg) && (mem_wdata[DEPTH_W-1:0] != DEPTH_INF)))
        else $error("bad depth write");

    // window scan stays inside its clipped bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WIN) |-> ((wx_reg <= u1_reg) && (wy_reg <= v1_reg)))
        else $error("window scan out of bounds");

endmodule
